// ----- src/life_pkg.sv -----
// Shared types and constants for the life automaton grid stepper.
package life_pkg;

	typedef enum logic [1:0] {
		OP_WRITE   = 2'd0,
		OP_ADVANCE = 2'd1,
		OP_READ    = 2'd2,
		OP_NOP     = 2'd3
	} op_t;

	localparam logic [7:0] REG_ACTIVE_ROWS = 8'd0;
	localparam logic [7:0] REG_ACTIVE_COLS = 8'd1;

	localparam logic [5:0] ROWS_RESET = 6'd25;
	localparam logic [6:0] COLS_RESET = 7'd39;

	localparam logic [3:0] BIRTH_COUNT   = 4'd3;
	localparam logic [3:0] SURVIVE_COUNT = 4'd2;

endpackage

// ----- src/life_automaton_grid_step.sv -----
// Grid of live and dead cells stepped under the B3/S23 rule, held in one row-wide memory.
//
// Commands arrive on the s_ stream: tuser carries the opcode, tdata the cell row,
// column and value to write. Each command gives exactly one result transfer on the
// m_ stream with the read cell state and an out-of-range flag.
// The cfg_ channel writes the active row count (index 0) and column count (index 1);
// it is always ready. The user must write it only while no command is in flight;
// the block does not enforce this. A cell write or read passes a read-wait state
// before its result; an out-of-range or no-op command goes straight to the result.
// An advance walks the active row count, clipped to MAX_ROWS: one grid row is read
// from the memory per cycle into a three-row window, and each new row is written
// back in place once the row below it has been read. Rows above the active area
// and columns to the right of it keep their contents.
// One command is processed at a time. The result register lets the next command be
// taken while a result waits; if the receiver stalls, the following command holds
// in its last cycle until the result register frees.
// Reset clears a per-row valid flag so every cell reads dead at once, with no
// clearing pass; the active area returns to 25 rows by 39 columns.
module life_automaton_grid_step #(
	parameter int unsigned MAX_ROWS = 32,
	parameter int unsigned MAX_COLS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // row[4:0], col[10:5], alive[11], zero[15:12]
	input  logic [1:0]  s_tuser,   // opcode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // cell_alive[0], out_of_range[1], zero[7:2]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_addr,
	input  logic [7:0]  cfg_data
);
	import life_pkg::*;

	localparam int unsigned RW = $clog2(MAX_ROWS);
	localparam int unsigned CW = $clog2(MAX_COLS);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_RDWAIT = 4'b0010,
		ST_ADV    = 4'b0100,
		ST_DONE   = 4'b1000
	} state_t;

	state_t              state_q;
	logic [5:0]          active_rows_q;
	logic [6:0]          active_cols_q;
	logic [6:0]          step_q;
	logic                m_tvalid_q;
	logic [7:0]          m_tdata_q;
	logic [MAX_ROWS-1:0] row_vld_q;

	logic [MAX_COLS-1:0] grid_q [MAX_ROWS];
	logic [MAX_COLS-1:0] rd_data_s1;
	logic                rd_vld_s1;
	logic                rd_live_s1;

	op_t                 op_q;
	logic [RW-1:0]       row_q;
	logic [CW-1:0]       col_q;
	logic                alive_q;
	logic                res_cell_q;
	logic                res_oor_q;
	logic [MAX_COLS-1:0] top_q;
	logic [MAX_COLS-1:0] mid_q;

	logic [5:0]          nr;
	logic [6:0]          nc;
	logic                in_acc;
	op_t                 in_op;
	logic [4:0]          in_row;
	logic [5:0]          in_col;
	logic                in_alive;
	logic                in_oor;
	logic [RW-1:0]       mem_raddr;
	logic [RW-1:0]       mem_waddr;
	logic [MAX_COLS-1:0] mem_wdata;
	logic                mem_we;
	logic [MAX_COLS-1:0] incoming;
	logic [MAX_COLS-1:0] wr_row;
	logic [MAX_COLS-1:0] colmask;
	logic [MAX_COLS-1:0] nxt;
	logic                adv_last;
	logic                out_load;

	assign nr = (32'(active_rows_q) > MAX_ROWS) ? 6'(MAX_ROWS) : active_rows_q;
	assign nc = (32'(active_cols_q) > MAX_COLS) ? 7'(MAX_COLS) : active_cols_q;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = s_tvalid && s_tready;
	assign in_op     = op_t'(s_tuser);
	assign in_row    = s_tdata[4:0];
	assign in_col    = s_tdata[10:5];
	assign in_alive  = s_tdata[11];
	assign in_oor    = ({1'b0, in_row} >= nr) || ({1'b0, in_col} >= nc);

	assign adv_last = (step_q == {1'b0, nr} + 7'd1);
	assign out_load = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign mem_raddr = (state_q == ST_ADV) ? RW'(step_q) : RW'(in_row);
	assign incoming  = (rd_live_s1 && rd_vld_s1) ? rd_data_s1 : '0;

	always_comb begin
		wr_row = incoming;
		wr_row[col_q] = alive_q;
	end

	always_comb begin
		for (int c = 0; c < MAX_COLS; c++) begin
			colmask[c] = (c < 32'(nc));
		end
	end

	always_comb begin
		logic [MAX_COLS-1:0] t;
		logic [MAX_COLS-1:0] m;
		logic [MAX_COLS-1:0] b;
		logic [3:0]          cnt;
		t = top_q & colmask;
		m = mid_q & colmask;
		b = incoming & colmask;
		for (int c = 0; c < MAX_COLS; c++) begin
			cnt = 4'(t[c]) + 4'(b[c]);
			if (c > 0) begin
				cnt = cnt + 4'(t[c-1]) + 4'(m[c-1]) + 4'(b[c-1]);
			end
			if (c < MAX_COLS - 1) begin
				cnt = cnt + 4'(t[c+1]) + 4'(m[c+1]) + 4'(b[c+1]);
			end
			nxt[c] = (cnt == BIRTH_COUNT) || (m[c] && (cnt == SURVIVE_COUNT));
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = row_q;
		mem_wdata = wr_row;
		case (state_q)
			ST_RDWAIT: begin
				mem_we = (op_q == OP_WRITE);
			end
			ST_ADV: begin
				mem_we    = (step_q >= 7'd2);
				mem_waddr = RW'(step_q - 7'd2);
				mem_wdata = (mid_q & ~colmask) | (nxt & colmask);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			grid_q[mem_waddr] <= mem_wdata;
		end
		rd_data_s1 <= grid_q[mem_raddr];
		rd_vld_s1  <= row_vld_q[mem_raddr];
		rd_live_s1 <= (state_q == ST_ADV) ? (step_q < {1'b0, nr}) : 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			active_rows_q <= ROWS_RESET;
			active_cols_q <= COLS_RESET;
			step_q        <= '0;
			m_tvalid_q    <= 1'b0;
			row_vld_q     <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_addr == REG_ACTIVE_ROWS) begin
					active_rows_q <= cfg_data[5:0];
				end else if (cfg_addr == REG_ACTIVE_COLS) begin
					active_cols_q <= cfg_data[6:0];
				end
			end
			if (mem_we) begin
				row_vld_q[mem_waddr] <= 1'b1;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						step_q <= '0;
						if (in_op == OP_ADVANCE) begin
							state_q <= (nr == 6'd0) ? ST_DONE : ST_ADV;
						end else if ((in_op == OP_WRITE || in_op == OP_READ) && !in_oor) begin
							state_q <= ST_RDWAIT;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_RDWAIT: begin
					state_q <= ST_DONE;
				end
				ST_ADV: begin
					step_q <= step_q + 7'd1;
					if (adv_last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q       <= in_op;
			row_q      <= RW'(in_row);
			col_q      <= CW'(in_col);
			alive_q    <= in_alive;
			res_cell_q <= 1'b0;
			res_oor_q  <= (in_op == OP_WRITE || in_op == OP_READ) && in_oor;
			top_q      <= '0;
			mid_q      <= '0;
		end
		if (state_q == ST_RDWAIT && op_q == OP_READ) begin
			res_cell_q <= incoming[col_q];
		end
		if (state_q == ST_ADV && step_q != 7'd0) begin
			top_q <= mid_q;
			mid_q <= incoming;
		end
		if (out_load) begin
			m_tdata_q <= {6'd0, res_oor_q, res_cell_q};
		end
	end

	a_we_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_ADV || state_q == ST_RDWAIT))
		else $error("grid memory written outside a command");

	a_adv_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADV && mem_we) |-> (mem_waddr != mem_raddr))
		else $error("advance write-back collides with row read");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADV) |-> (step_q <= {1'b0, nr} + 7'd1))
		else $error("advance step counter ran past the last row");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready && state_q == ST_DONE) |=> (state_q == ST_DONE))
		else $error("result dropped while the output register was full");

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the life automaton grid stepper with a cell-level predictor.
`timescale 1ns / 100ps

module tb;
	import life_pkg::*;

	localparam int CYCLE_LIMIT = 500000;

	typedef struct packed {
		logic cell_alive;
		logic out_of_range;
	} cell_result_t;

	class life_scoreboard;
		logic [63:0]  cells [32];
		logic [5:0]   rows_reg;
		logic [6:0]   cols_reg;
		cell_result_t expected_q [$];
		int           failures;

		function new();
			foreach (cells[r]) cells[r] = '0;
			rows_reg = ROWS_RESET;
			cols_reg = COLS_RESET;
			failures = 0;
		endfunction

		function int rows_in_use();
			return (rows_reg > 32) ? 32 : int'(rows_reg);
		endfunction

		function int cols_in_use();
			return (cols_reg > 64) ? 64 : int'(cols_reg);
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction

		function void write_reg(logic [7:0] addr, logic [7:0] data);
			if (addr == REG_ACTIVE_ROWS) begin
				rows_reg = data[5:0];
			end else if (addr == REG_ACTIVE_COLS) begin
				cols_reg = data[6:0];
			end
		endfunction

		function int alive_at(int r, int c, int nr, int nc);
			if (r < 0 || c < 0 || r >= nr || c >= nc) begin
				return 0;
			end
			return int'(cells[r][c]);
		endfunction

		function void step_generation();
			logic [63:0] fresh [32];
			logic [63:0] mask;
			int          nr;
			int          nc;
			int          count;
			nr = rows_in_use();
			nc = cols_in_use();
			foreach (fresh[r]) fresh[r] = '0;
			for (int r = 0; r < nr; r++) begin
				for (int c = 0; c < nc; c++) begin
					count = 0;
					for (int dr = -1; dr <= 1; dr++) begin
						for (int dc = -1; dc <= 1; dc++) begin
							if (dr != 0 || dc != 0) begin
								count += alive_at(r + dr, c + dc, nr, nc);
							end
						end
					end
					if (alive_at(r, c, nr, nc) != 0) begin
						fresh[r][c] = (count == 2 || count == 3);
					end else begin
						fresh[r][c] = (count == 3);
					end
				end
			end
			mask = (nc >= 64) ? '1 : ((64'd1 << nc) - 64'd1);
			for (int r = 0; r < nr; r++) begin
				cells[r] = (cells[r] & ~mask) | (fresh[r] & mask);
			end
		endfunction

		function void note_command(op_t op, logic [4:0] row, logic [5:0] col, logic alive);
			cell_result_t res;
			res = '0;
			case (op)
				OP_ADVANCE: begin
					step_generation();
				end
				OP_WRITE, OP_READ: begin
					if (int'(row) >= rows_in_use() || int'(col) >= cols_in_use()) begin
						res.out_of_range = 1'b1;
					end else if (op == OP_WRITE) begin
						cells[row][col] = alive;
					end else begin
						res.cell_alive = cells[row][col];
					end
				end
				default: begin
				end
			endcase
			expected_q.push_back(res);
		endfunction

		function void check_result(logic [7:0] data);
			cell_result_t want;
			if (expected_q.size() == 0) begin
				$error("result transfer with nothing expected: %h", data);
				failures++;
				return;
			end
			want = expected_q.pop_front();
			if (data[0] !== want.cell_alive) begin
				$error("cell_alive expected %0d actual %0d", want.cell_alive, data[0]);
				failures++;
			end
			if (data[1] !== want.out_of_range) begin
				$error("out_of_range expected %0d actual %0d", want.out_of_range, data[1]);
				failures++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // row[4:0], col[10:5], alive[11], zero[15:12]
	logic [1:0]  s_tuser;   // opcode[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // cell_alive[0], out_of_range[1], zero[7:2]
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_addr;
	logic [7:0]  cfg_data;

	life_scoreboard board;
	bit             no_idle;
	int             cycle_count;

	life_automaton_grid_step DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 27);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				board.write_reg(cfg_addr, cfg_data);
			end
			if (s_tvalid && s_tready) begin
				board.note_command(op_t'(s_tuser), s_tdata[4:0], s_tdata[10:5], s_tdata[11]);
			end
			if (m_tvalid && m_tready) begin
				board.check_result(m_tdata);
			end
		end
	end

	task automatic send_command(input op_t op, input int row, input int col, input bit alive);
		while (!no_idle && $urandom_range(99) < 27) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {4'b0, alive, col[5:0], row[4:0]};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic write_config(input logic [7:0] rows, input logic [7:0] cols);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (board.outstanding() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_addr  <= REG_ACTIVE_ROWS;
		cfg_data  <= rows;
		do @(posedge clk); while (!cfg_ready);
		cfg_addr  <= REG_ACTIVE_COLS;
		cfg_data  <= cols;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_random(input int count);
		int   nr;
		int   nc;
		int   pick;
		int   row;
		int   col;
		op_t  op;
		for (int i = 0; i < count; i++) begin
			nr   = board.rows_in_use();
			nc   = board.cols_in_use();
			pick = $urandom_range(99);
			if (pick < 5) begin
				op = OP_NOP;
			end else if (pick < 20) begin
				op = OP_ADVANCE;
			end else if (pick < 60) begin
				op = OP_WRITE;
			end else begin
				op = OP_READ;
			end
			row = (nr > 0 && $urandom_range(9) != 0) ? $urandom_range(nr - 1) : $urandom_range(31);
			col = (nc > 0 && $urandom_range(9) != 0) ? $urandom_range(nc - 1) : $urandom_range(63);
			send_command(op, row, col, $urandom_range(99) < 60);
		end
	endtask

	initial begin
		board     = new();
		no_idle   = 1'b0;
		cycle_count = 0;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= OP_NOP;
		m_tready  <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_addr  <= '0;
		cfg_data  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset area is 25 by 39; a blinker on the bottom-right corner checks that edges do not wrap.
		send_command(OP_READ, 0, 0, 1'b0);
		send_command(OP_WRITE, 0, 0, 1'b1);
		send_command(OP_READ, 0, 0, 1'b0);
		send_command(OP_WRITE, 24, 38, 1'b1);
		send_command(OP_READ, 24, 38, 1'b0);
		send_command(OP_WRITE, 25, 0, 1'b1);
		send_command(OP_WRITE, 0, 39, 1'b1);
		send_command(OP_WRITE, 31, 63, 1'b1);
		send_command(OP_READ, 31, 63, 1'b1);
		send_command(OP_READ, 25, 38, 1'b0);
		send_command(OP_WRITE, 24, 36, 1'b1);
		send_command(OP_WRITE, 24, 37, 1'b1);
		send_command(OP_ADVANCE, 31, 63, 1'b1);
		send_command(OP_READ, 23, 37, 1'b0);
		send_command(OP_READ, 24, 37, 1'b0);
		send_command(OP_READ, 24, 38, 1'b0);
		send_command(OP_READ, 0, 0, 1'b0);
		send_command(OP_NOP, 31, 63, 1'b1);
		send_command(OP_WRITE, 12, 20, 1'b1);
		send_command(OP_WRITE, 12, 20, 1'b0);
		send_command(OP_READ, 12, 20, 1'b0);
		send_command(OP_ADVANCE, 0, 0, 1'b0);

		write_config(8'd32, 8'd64);
		no_idle = 1'b1;
		run_random(150);
		no_idle = 1'b0;
		run_random(150);
		write_config(8'd1, 8'd1);
		run_random(60);
		write_config(8'd3, 8'd3);
		run_random(100);
		write_config(8'd0, 8'd0);
		run_random(40);
		write_config(8'd63, 8'd127);
		run_random(150);
		write_config(8'd6, 8'd8);
		run_random(200);
		write_config(8'($urandom_range(1, 32)), 8'($urandom_range(1, 64)));
		run_random(200);
		write_config(8'd32, 8'd1);
		run_random(50);
		write_config(8'd1, 8'd64);
		run_random(50);
		write_config(8'd25, 8'd39);
		run_random(50);

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (board.outstanding() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (board.failures == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ----- files.f -----
src/life_pkg.sv
src/life_automaton_grid_step.sv
test/tb.sv
